>>> hdl/aos_pkg.sv
// Shared types and constants for the ADC oversampling averager with peak capture.
// Used by aos_upd and the top level; no dependencies.
`timescale 1ns / 1ps
package aos_pkg;

	localparam int ADC_W            = 12;
	localparam int LOG2_SAMPLES_DEF = 4;
	localparam int NUM_CH           = 4;
	localparam int CH_W             = 2;
	localparam int PF_W             = 4;

	// RAM entry / channel numbering
	localparam logic [CH_W-1:0] CH_U  = 2'd0;
	localparam logic [CH_W-1:0] CH_V  = 2'd1;
	localparam logic [CH_W-1:0] CH_W_ = 2'd2;
	localparam logic [CH_W-1:0] CH_DC = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_OFFSET_U = 2'd0;
	localparam logic [1:0] REG_OFFSET_V = 2'd1;
	localparam logic [1:0] REG_OFFSET_W = 2'd2;

	localparam logic [ADC_W-1:0] OFFSET_RESET = 12'd2048;

	typedef struct packed {
		logic [ADC_W-1:0] sample_u;
		logic [ADC_W-1:0] sample_v;
		logic [ADC_W-1:0] sample_w;
		logic [ADC_W-1:0] sample_dc;
		logic             overcurrent_flag;
		logic             frame_last;
	} in_t;

	typedef struct packed {
		logic [ADC_W-1:0] out_u;
		logic [ADC_W-1:0] out_v;
		logic [ADC_W-1:0] out_w;
		logic [ADC_W-1:0] out_dc;
		logic             peak_used;
		logic [PF_W-1:0]  peak_frame;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SWEEP = 2'b10
	} state_t;

endpackage

>>> hdl/aos_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module aos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/aos_upd.sv
// Per-channel read-modify-write update: running sum and peak-deviation tracking.
// Depends on aos_pkg.
`timescale 1ns / 1ps
module aos_upd #(
	parameter int SUM_W = 16,
	parameter int IDX_W = 4
) (
	input  logic                        is_phase,
	input  logic                        first,
	input  logic [aos_pkg::ADC_W-1:0]   sample,
	input  logic [aos_pkg::ADC_W-1:0]   offset,
	input  logic [3*aos_pkg::ADC_W-1:0] trip,
	input  logic [IDX_W-1:0]            idx,
	input  logic [SUM_W-1:0]            old_sum,
	input  logic [2*aos_pkg::ADC_W-1:0] old_sq,
	input  logic [IDX_W-1:0]            old_idx,
	input  logic [3*aos_pkg::ADC_W-1:0] old_trip,
	output logic [SUM_W-1:0]            new_sum,
	output logic [2*aos_pkg::ADC_W-1:0] new_sq,
	output logic [IDX_W-1:0]            new_idx,
	output logic [3*aos_pkg::ADC_W-1:0] new_trip
);

	localparam int SQ_W = 2 * aos_pkg::ADC_W;

	logic [aos_pkg::ADC_W-1:0] diff;
	logic [SQ_W-1:0]           sq;
	logic                      take;

	always_comb begin
		diff = (sample >= offset) ? (sample - offset) : (offset - sample);
		sq   = SQ_W'(diff) * SQ_W'(diff);
		// first frame of a burst always wins; later ones only when strictly larger
		take = first || (sq > old_sq);

		new_sum = old_sum + SUM_W'(sample);
		if (!is_phase) begin
			new_sq   = '0;
			new_idx  = '0;
			new_trip = '0;
		end else if (take) begin
			new_sq   = sq;
			new_idx  = idx;
			new_trip = trip;
		end else begin
			new_sq   = old_sq;
			new_idx  = old_idx;
			new_trip = old_trip;
		end
	end

endmodule

>>> hdl/adc_oversample_avg_peak_capture.sv
// Top level of the ADC oversampling averager with peak-frame capture.
// Depends on aos_pkg, aos_ram and aos_upd.
//
// Usage:
//  - Input: drive frame and raise start; the request is taken at a clock edge
//    with start high and busy low. Each request is one frame of U, V, W and DC
//    samples; frame_last closes a burst.
//  - Output: on a closing frame one result appears on result for exactly one
//    cycle with result_valid high; the receiver cannot stall it.
//  - Config: cfg_valid/cfg_ready write offset_u/v/w (cfg_index 0..2);
//    cfg_ready is always high, other indexes are ignored.
//  - Sweep: busy holds off new frames until a sweep ends. The per-channel
//    state (sum, peak square, peak index, peak triple) lives in one 4-entry RAM
//    with a single read port; each frame sweeps the four entries one per cycle.
//  - Reset: offsets go to 2048, frame counter and entry valid bits clear, so
//    all channel state reads as zero; no clearing pass is needed. A closing
//    frame invalidates all entries for the next burst.
`timescale 1ns / 1ps
module adc_oversample_avg_peak_capture #(
	parameter int LOG2_SAMPLES = aos_pkg::LOG2_SAMPLES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  aos_pkg::in_t              frame,
	output logic                      result_valid,
	output aos_pkg::out_t             result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [aos_pkg::ADC_W-1:0] cfg_data
);

	localparam int AW      = aos_pkg::ADC_W;
	localparam int SUM_W   = AW + LOG2_SAMPLES;
	localparam int SQ_W    = 2 * AW;
	localparam int IDX_W   = LOG2_SAMPLES;
	localparam int TRIP_W  = 3 * AW;
	localparam int ENTRY_W = SUM_W + SQ_W + IDX_W + TRIP_W;
	localparam int CW      = aos_pkg::CH_W;
	localparam logic [IDX_W-1:0] LAST_IDX = {IDX_W{1'b1}};

	aos_pkg::state_t state_q;
	logic [CW-1:0]   rd_cnt_q;
	logic            rd_en;

	logic [AW-1:0]   smp_q [aos_pkg::NUM_CH];
	logic            oc_q;
	logic            last_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] cnt_q;
	logic [AW-1:0]   off_u_q, off_v_q, off_w_q;
	logic [aos_pkg::NUM_CH-1:0] vld_q;

	logic            p_vld_s1;
	logic [CW-1:0]   p_ch_s1;
	logic            rvld_s1;

	logic [ENTRY_W-1:0] rdata, old_word, new_word;
	logic [SUM_W-1:0]   new_sum;
	logic [SQ_W-1:0]    new_sq;
	logic [IDX_W-1:0]   new_idx;
	logic [TRIP_W-1:0]  new_trip;
	logic [AW-1:0]      cur_smp, cur_off;
	logic               accept;

	logic [SQ_W-1:0]    best_sq_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [TRIP_W-1:0]  best_trip_q;
	logic               tie_q;
	logic [AW-1:0]      avg_u_q, avg_v_q, avg_w_q;
	logic [AW-1:0]      new_avg;

	aos_pkg::out_t      res_q;
	logic               res_vld_q;

	assign accept    = start && !busy;
	assign busy      = (state_q == aos_pkg::ST_SWEEP);
	assign rd_en     = (state_q == aos_pkg::ST_SWEEP);
	assign cfg_ready = 1'b1;

	// sequencer: one RAM read per channel entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= aos_pkg::ST_IDLE;
			rd_cnt_q <= '0;
			p_vld_s1 <= 1'b0;
			p_ch_s1  <= '0;
		end else begin
			p_vld_s1 <= rd_en;
			p_ch_s1  <= rd_cnt_q;
			case (state_q)
				aos_pkg::ST_IDLE: begin
					rd_cnt_q <= '0;
					if (accept) begin
						state_q <= aos_pkg::ST_SWEEP;
					end
				end
				aos_pkg::ST_SWEEP: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == aos_pkg::CH_DC) begin
						state_q <= aos_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= aos_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// request capture and frame counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (frame.frame_last) begin
				cnt_q <= '0;
			end else if (cnt_q != LAST_IDX) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q[aos_pkg::CH_U]  <= frame.sample_u;
			smp_q[aos_pkg::CH_V]  <= frame.sample_v;
			smp_q[aos_pkg::CH_W_] <= frame.sample_w;
			smp_q[aos_pkg::CH_DC] <= frame.sample_dc;
			oc_q   <= frame.overcurrent_flag;
			last_q <= frame.frame_last;
			idx_q  <= cnt_q;
		end
	end

	// offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_u_q <= aos_pkg::OFFSET_RESET;
			off_v_q <= aos_pkg::OFFSET_RESET;
			off_w_q <= aos_pkg::OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				aos_pkg::REG_OFFSET_U: off_u_q <= cfg_data;
				aos_pkg::REG_OFFSET_V: off_v_q <= cfg_data;
				aos_pkg::REG_OFFSET_W: off_w_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// entry valid bits; a closing frame invalidates each entry as it passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (rd_en) begin
				rvld_s1 <= vld_q[rd_cnt_q];
			end
			if (p_vld_s1) begin
				vld_q[p_ch_s1] <= !last_q;
			end
		end
	end

	aos_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (aos_pkg::NUM_CH)
	) u_ram (
		.clk   (clk),
		.we    (p_vld_s1 && !last_q),
		.waddr (p_ch_s1),
		.wdata (new_word),
		.re    (rd_en),
		.raddr (rd_cnt_q),
		.rdata (rdata)
	);

	assign old_word = rvld_s1 ? rdata : '0;

	always_comb begin
		cur_smp = smp_q[p_ch_s1];
		case (p_ch_s1)
			aos_pkg::CH_U:  cur_off = off_u_q;
			aos_pkg::CH_V:  cur_off = off_v_q;
			aos_pkg::CH_W_: cur_off = off_w_q;
			default:        cur_off = '0;
		endcase
	end

	aos_upd #(
		.SUM_W (SUM_W),
		.IDX_W (IDX_W)
	) u_upd (
		.is_phase (p_ch_s1 != aos_pkg::CH_DC),
		.first    (idx_q == '0),
		.sample   (cur_smp),
		.offset   (cur_off),
		.trip     ({smp_q[aos_pkg::CH_U], smp_q[aos_pkg::CH_V], smp_q[aos_pkg::CH_W_]}),
		.idx      (idx_q),
		.old_sum  (old_word[ENTRY_W-1 -: SUM_W]),
		.old_sq   (old_word[IDX_W+TRIP_W +: SQ_W]),
		.old_idx  (old_word[TRIP_W +: IDX_W]),
		.old_trip (old_word[TRIP_W-1:0]),
		.new_sum  (new_sum),
		.new_sq   (new_sq),
		.new_idx  (new_idx),
		.new_trip (new_trip)
	);

	assign new_word = {new_sum, new_sq, new_idx, new_trip};
	assign new_avg  = new_sum[SUM_W-1:LOG2_SAMPLES];

	// averages and phase pick: W unless U or V holds a strictly unique maximum; the DC entry builds the result
	always_ff @(posedge clk) begin
		if (p_vld_s1) begin
			case (p_ch_s1)
				aos_pkg::CH_U: begin
					avg_u_q     <= new_avg;
					best_sq_q   <= new_sq;
					best_idx_q  <= new_idx;
					best_trip_q <= new_trip;
					tie_q       <= 1'b0;
				end
				aos_pkg::CH_V: begin
					avg_v_q <= new_avg;
					if (new_sq > best_sq_q) begin
						best_sq_q   <= new_sq;
						best_idx_q  <= new_idx;
						best_trip_q <= new_trip;
						tie_q       <= 1'b0;
					end else if (new_sq == best_sq_q) begin
						tie_q <= 1'b1;
					end
				end
				aos_pkg::CH_W_: begin
					avg_w_q <= new_avg;
					if (new_sq >= best_sq_q || tie_q) begin
						best_sq_q   <= new_sq;
						best_idx_q  <= new_idx;
						best_trip_q <= new_trip;
					end
				end
				default: begin
					if (oc_q) begin
						res_q.out_u      <= best_trip_q[TRIP_W-1 -: AW];
						res_q.out_v      <= best_trip_q[AW +: AW];
						res_q.out_w      <= best_trip_q[AW-1:0];
						res_q.peak_used  <= 1'b1;
						res_q.peak_frame <= aos_pkg::PF_W'(best_idx_q);
					end else begin
						res_q.out_u      <= avg_u_q;
						res_q.out_v      <= avg_v_q;
						res_q.out_w      <= avg_w_q;
						res_q.peak_used  <= 1'b0;
						res_q.peak_frame <= '0;
					end
					res_q.out_dc <= new_avg;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= p_vld_s1 && (p_ch_s1 == aos_pkg::CH_DC) && last_q;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

>>> verif/tb_top.sv
// Self-checking bench for adc_oversample_avg_peak_capture: a queue-fed frame driver,
// a readout monitor with a frame-level predictor, and offset writes between phases.
// Depends on aos_pkg and the RTL top level.
`timescale 1ns / 1ps
module tb_top;

	localparam int          ADC_W       = aos_pkg::ADC_W;
	localparam int          AVG_SHIFT   = aos_pkg::LOG2_SAMPLES_DEF;
	localparam int          SUM_W       = ADC_W + AVG_SHIFT;
	localparam int          SQ_W        = 2 * ADC_W;
	localparam int          IN_W        = $bits(aos_pkg::in_t);
	localparam logic [3:0]  LAST_SLOT   = 4'((1 << aos_pkg::LOG2_SAMPLES_DEF) - 1);
	localparam logic [1:0]  REG_UNUSED  = 2'd3;
	localparam int          STALL_LIMIT = 3000;
	localparam int          DRAIN_CYCLES = 8;

	// sample shaping for random bursts
	localparam int STYLE_WIDE = 0;
	localparam int STYLE_TIES = 1;
	localparam int STYLE_EDGE = 2;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	aos_pkg::in_t      frame = '0;
	logic              result_valid;
	aos_pkg::out_t     result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = aos_pkg::REG_OFFSET_U;
	logic [ADC_W-1:0]  cfg_data = '0;

	adc_oversample_avg_peak_capture u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.frame        (frame),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	aos_pkg::in_t     pending_frames[$];
	aos_pkg::out_t    expected_readouts[$];
	int               idle_pct = 26;
	int               items_queued = 0;
	logic [ADC_W-1:0] programmed_offset [3] = '{aos_pkg::OFFSET_RESET,
		aos_pkg::OFFSET_RESET, aos_pkg::OFFSET_RESET};

	// predictor copy of the burst state
	logic [ADC_W-1:0]               zero_code [3];
	logic [SUM_W-1:0]               burst_sum [aos_pkg::NUM_CH];
	logic [3:0]                     frame_slot;
	logic [SQ_W-1:0]                peak_sq [3];
	logic [3:0]                     peak_slot [3];
	logic [ADC_W-1:0]               peak_trip [3][3];

	int frames_taken = 0;
	int readouts_checked = 0;
	int peak_readouts = 0;
	int offset_writes = 0;
	int mismatches = 0;
	int stall_cycles = 0;

	task automatic clear_burst_state();
		for (int i = 0; i < aos_pkg::NUM_CH; i++)
			burst_sum[i] = '0;
		frame_slot = '0;
		for (int i = 0; i < 3; i++) begin
			peak_sq[i] = '0;
			peak_slot[i] = '0;
			for (int j = 0; j < 3; j++)
				peak_trip[i][j] = '0;
		end
	endtask

	// fold one accepted frame into the burst; a closing frame yields a readout
	task automatic fold_frame(input aos_pkg::in_t f);
		logic [ADC_W-1:0]   s [aos_pkg::NUM_CH];
		logic [ADC_W-1:0]   d;
		logic [SQ_W-1:0]    sq;
		logic [1:0]         sel;
		aos_pkg::out_t      r;
		s[aos_pkg::CH_U] = f.sample_u;
		s[aos_pkg::CH_V] = f.sample_v;
		s[aos_pkg::CH_W_] = f.sample_w;
		s[aos_pkg::CH_DC] = f.sample_dc;
		for (int i = 0; i < aos_pkg::NUM_CH; i++)
			burst_sum[i] = burst_sum[i] + SUM_W'(s[i]);
		for (int i = 0; i < 3; i++) begin
			d = (s[i] >= zero_code[i]) ? s[i] - zero_code[i] : zero_code[i] - s[i];
			sq = SQ_W'(d) * SQ_W'(d);
			if (frame_slot == '0 || sq > peak_sq[i]) begin
				peak_sq[i] = sq;
				peak_slot[i] = frame_slot;
				for (int j = 0; j < 3; j++)
					peak_trip[i][j] = s[j];
			end
		end
		if (frame_slot != LAST_SLOT)
			frame_slot = frame_slot + 1'b1;
		if (f.frame_last) begin
			if (f.overcurrent_flag) begin
				if (peak_sq[aos_pkg::CH_U] > peak_sq[aos_pkg::CH_V] &&
					peak_sq[aos_pkg::CH_U] > peak_sq[aos_pkg::CH_W_])
					sel = aos_pkg::CH_U;
				else if (peak_sq[aos_pkg::CH_V] > peak_sq[aos_pkg::CH_U] &&
					peak_sq[aos_pkg::CH_V] > peak_sq[aos_pkg::CH_W_])
					sel = aos_pkg::CH_V;
				else
					sel = aos_pkg::CH_W_;
				r.out_u = peak_trip[sel][aos_pkg::CH_U];
				r.out_v = peak_trip[sel][aos_pkg::CH_V];
				r.out_w = peak_trip[sel][aos_pkg::CH_W_];
				r.peak_used = 1'b1;
				r.peak_frame = peak_slot[sel];
			end else begin
				r.out_u = ADC_W'(burst_sum[aos_pkg::CH_U] >> AVG_SHIFT);
				r.out_v = ADC_W'(burst_sum[aos_pkg::CH_V] >> AVG_SHIFT);
				r.out_w = ADC_W'(burst_sum[aos_pkg::CH_W_] >> AVG_SHIFT);
				r.peak_used = 1'b0;
				r.peak_frame = '0;
			end
			r.out_dc = ADC_W'(burst_sum[aos_pkg::CH_DC] >> AVG_SHIFT);
			expected_readouts.push_back(r);
			clear_burst_state();
		end
	endtask

	// frame driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			frame <= '0;
		end else if (!start || !busy) begin
			if (pending_frames.size() != 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				frame <= pending_frames.pop_front();
			end else begin
				start <= 1'b0;
				frame <= IN_W'({$urandom, $urandom});
			end
		end
	end

	// monitor: tracks offset writes, predicts on each request, checks readouts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				zero_code[i] = aos_pkg::OFFSET_RESET;
			clear_burst_state();
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (cfg_valid && cfg_ready) begin
				stall_cycles = 0;
				offset_writes++;
				case (cfg_index)
					aos_pkg::REG_OFFSET_U: zero_code[0] = cfg_data;
					aos_pkg::REG_OFFSET_V: zero_code[1] = cfg_data;
					aos_pkg::REG_OFFSET_W: zero_code[2] = cfg_data;
					default: ;
				endcase
			end
			if (result_valid) begin
				stall_cycles = 0;
				if (expected_readouts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected readout: u=%0d v=%0d w=%0d dc=%0d peak=%0b frame=%0d",
							result.out_u, result.out_v, result.out_w, result.out_dc,
							result.peak_used, result.peak_frame);
				end else begin
					aos_pkg::out_t e;
					e = expected_readouts.pop_front();
					readouts_checked++;
					if (e.peak_used)
						peak_readouts++;
					if (result.out_u !== e.out_u || result.out_v !== e.out_v ||
						result.out_w !== e.out_w || result.out_dc !== e.out_dc ||
						result.peak_used !== e.peak_used || result.peak_frame !== e.peak_frame) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("readout mismatch: exp u=%0d v=%0d w=%0d dc=%0d peak=%0b frame=%0d",
								e.out_u, e.out_v, e.out_w, e.out_dc, e.peak_used, e.peak_frame);
							$display("                  got u=%0d v=%0d w=%0d dc=%0d peak=%0b frame=%0d",
								result.out_u, result.out_v, result.out_w, result.out_dc,
								result.peak_used, result.peak_frame);
						end
					end
				end
			end
			if (start && !busy) begin
				stall_cycles = 0;
				frames_taken++;
				fold_frame(frame);
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
				$display("adc_oversample_avg_peak_capture regression: fail");
				$finish;
			end
		end
	end

	function automatic aos_pkg::in_t mk_frame(input logic [ADC_W-1:0] u, v, w, dc,
		input logic oc, last);
		aos_pkg::in_t f;
		f.sample_u = u;
		f.sample_v = v;
		f.sample_w = w;
		f.sample_dc = dc;
		f.overcurrent_flag = oc;
		f.frame_last = last;
		return f;
	endfunction

	function automatic logic [ADC_W-1:0] pick_code(input int style, input logic [ADC_W-1:0] off);
		case (style)
			STYLE_TIES: return ADC_W'(off + $urandom_range(4) - 2);
			STYLE_EDGE: begin
				case ($urandom_range(3))
					0: return '0;
					1: return '1;
					2: return off;
					default: return ~off;
				endcase
			end
			default: begin
				if ($urandom_range(7) == 0)
					return $urandom_range(1) ? '1 : '0;
				return ADC_W'($urandom_range(4095));
			end
		endcase
	endfunction

	task automatic queue_burst(input int len, input int style, input logic oc_last);
		aos_pkg::in_t f;
		for (int n = 0; n < len; n++) begin
			f.sample_u = pick_code(style, programmed_offset[0]);
			f.sample_v = pick_code(style, programmed_offset[1]);
			f.sample_w = pick_code(style, programmed_offset[2]);
			f.sample_dc = ADC_W'($urandom_range(4095));
			f.frame_last = (n == len - 1);
			f.overcurrent_flag = f.frame_last ? oc_last : 1'($urandom_range(1));
			pending_frames.push_back(f);
		end
		items_queued += len;
	endtask

	// mostly full bursts, some short, some past the saturating frame count
	task automatic random_phase(input int n_items);
		int target;
		int len;
		int style;
		target = items_queued + n_items;
		while (items_queued < target) begin
			case ($urandom_range(9))
				0: len = $urandom_range(15, 1);
				1: len = $urandom_range(22, 17);
				default: len = 16;
			endcase
			case ($urandom_range(5))
				0, 1: style = STYLE_TIES;
				2: style = STYLE_EDGE;
				default: style = STYLE_WIDE;
			endcase
			queue_burst(len, style, $urandom_range(99) < 45);
		end
	endtask

	task automatic write_offset(input logic [1:0] idx, input logic [ADC_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx != REG_UNUSED)
			programmed_offset[idx] = val;
	endtask

	task automatic set_offsets(input logic [ADC_W-1:0] u, v, w);
		write_offset(aos_pkg::REG_OFFSET_U, u);
		write_offset(aos_pkg::REG_OFFSET_V, v);
		write_offset(aos_pkg::REG_OFFSET_W, w);
		if ($urandom_range(1))
			write_offset(REG_UNUSED, ADC_W'($urandom_range(4095)));
	endtask

	// block is idle once no request is pending and every readout has come back
	task automatic settle();
		while (pending_frames.size() != 0 || start || expected_readouts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// short burst of zeros; flag on a non-closing frame is ignored
		pending_frames.push_back(mk_frame(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 1'b0));
		pending_frames.push_back(mk_frame(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b1));
		// no deviation on any phase: three-way tie picks W, frame 0
		pending_frames.push_back(mk_frame(12'd2048, 12'd2048, 12'd2048, 12'd4095, 1'b0, 1'b0));
		pending_frames.push_back(mk_frame(12'd2048, 12'd2048, 12'd2048, 12'd4095, 1'b1, 1'b1));
		// long burst of full-scale codes: frame count saturates, sums wrap
		for (int n = 0; n < 18; n++)
			pending_frames.push_back(mk_frame(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
				1'(n % 2), n == 17));
		// equal deviation of opposite sign on U: the first frame keeps the peak
		pending_frames.push_back(mk_frame(12'd2148, 12'd2048, 12'd2048, 12'd100, 1'b0, 1'b0));
		pending_frames.push_back(mk_frame(12'd1948, 12'd2048, 12'd2048, 12'd200, 1'b0, 1'b0));
		pending_frames.push_back(mk_frame(12'd2048, 12'd2048, 12'd2048, 12'd300, 1'b1, 1'b1));
		items_queued = 25;
		settle();

		random_phase(150);
		settle();

		set_offsets(12'd0, 12'd0, 12'd0);
		random_phase(200);
		settle();

		set_offsets(12'hFFF, 12'hFFF, 12'hFFF);
		idle_pct = 0;
		random_phase(200);
		settle();
		idle_pct = 26;

		set_offsets(ADC_W'($urandom_range(4095)), ADC_W'($urandom_range(4095)),
			ADC_W'($urandom_range(4095)));
		random_phase(250);
		settle();

		set_offsets(12'd0, 12'hFFF, aos_pkg::OFFSET_RESET);
		random_phase(200);
		settle();

		set_offsets(ADC_W'($urandom_range(4095)), ADC_W'($urandom_range(4095)),
			ADC_W'($urandom_range(4095)));
		write_offset(REG_UNUSED, 12'hFFF);
		random_phase(200);
		settle();

		if (expected_readouts.size() != 0) begin
			$display("%0d expected readouts never arrived", expected_readouts.size());
			mismatches += expected_readouts.size();
		end
		$display("covered %0d frames, %0d readouts checked (%0d peak captures, rest averages)",
			frames_taken, readouts_checked, peak_readouts);
		$display("%0d offset writes across six offset settings, %0d mismatches",
			offset_writes, mismatches);
		if (mismatches == 0)
			$display("adc_oversample_avg_peak_capture regression: pass");
		else
			$display("adc_oversample_avg_peak_capture regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
hdl/aos_pkg.sv
hdl/aos_ram.sv
hdl/aos_upd.sv
hdl/adc_oversample_avg_peak_capture.sv
verif/tb_top.sv
